FILE: hdl/pbp_pkg.sv
// shared types and constants for the page buffer pool with lru replacement
// no dependencies

package pbp_pkg;

    localparam int NUM_FRAMES = 16;
    localparam int MAX_PINS   = 255;
    localparam int PAGE_W     = 31;
    localparam int OP_W       = 3;
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
    localparam int PIN_W      = $clog2(MAX_PINS + 1);

    typedef enum logic [OP_W-1:0] {
        OP_FETCH  = 3'd0,
        OP_NEW    = 3'd1,
        OP_UNPIN  = 3'd2,
        OP_FLUSH  = 3'd3,
        OP_DELETE = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_RES  = 2'd1,
        ST_NO_FRAME = 2'd2,
        ST_PIN_ERR  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK_RD,
        S_LOOK_CMP,
        S_DECIDE,
        S_TAKE,
        S_EVICT,
        S_FILL,
        S_LRU_SCAN,
        S_LRU_PUSH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [PAGE_W-1:0] page_id;
        logic [PAGE_W-1:0] allocated_page;
        logic              mark_dirty;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] frame;
        logic               disk_write_valid;
        logic [PAGE_W-1:0]  disk_write_page;
        logic               disk_read_valid;
    } t_rsp;

endpackage

FILE: hdl/page_buffer_pool_lru_top.sv
// flow from input transfer to result valid: a lookup scan that reads and compares each frame
// in turn until a hit (ram read, compare), a replacer scan over the lru entries, and the sequencing states;
// fetch, unpin, flush and delete run the lookup scan, new page skips it, an unknown opcode
// goes straight to the result; the result waits while the result register is stalled
// throughput: one request at a time, the next transfer accepted in the cycle after the result loads
// reset: frame table and replacer empty, free list holds all frames in order

module page_buffer_pool_lru_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  pbp_pkg::t_req i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output pbp_pkg::t_rsp o_out_data
);

    import pbp_pkg::*;

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [PAGE_W-1:0]   r_alloc, n_alloc;
    logic                r_mark, n_mark;
    logic [FRAME_W-1:0]  r_idx, n_idx;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic                r_hit, n_hit;
    logic                r_push, n_push;
    t_rsp                r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_rsp                r_out, n_out;

    logic                r_fvalid [NUM_FRAMES];
    logic                n_fvalid [NUM_FRAMES];
    logic [PIN_W-1:0]    r_pins   [NUM_FRAMES];
    logic [PIN_W-1:0]    n_pins   [NUM_FRAMES];
    logic                r_dirty  [NUM_FRAMES];
    logic                n_dirty  [NUM_FRAMES];
    logic [FRAME_W-1:0]  r_fq     [NUM_FRAMES];
    logic [FRAME_W-1:0]  n_fq     [NUM_FRAMES];
    logic [FRAME_W-1:0]  r_fq_head, n_fq_head;
    logic [CNT_W-1:0]    r_fq_cnt, n_fq_cnt;
    logic [FRAME_W-1:0]  r_lru    [NUM_FRAMES];
    logic [FRAME_W-1:0]  n_lru    [NUM_FRAMES];
    logic [CNT_W-1:0]    r_lru_cnt, n_lru_cnt;

    logic                ram_we;
    logic [FRAME_W-1:0]  ram_raddr;
    logic [PAGE_W-1:0]   ram_wdata;
    logic [PAGE_W-1:0]   ram_rdata;

    logic [FRAME_W:0]    fq_tail;
    logic [FRAME_W-1:0]  fq_tail_idx;
    logic                in_xfer;
    logic                out_free;
    logic [FRAME_W-1:0]  shift_from;
    logic                do_shift;

    pbp_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (NUM_FRAMES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_frame),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign ram_wdata = (r_op == OP_FETCH) ? r_page : r_alloc;

    always_comb begin
        fq_tail = {1'b0, r_fq_head} + r_fq_cnt[FRAME_W:0];
        if (fq_tail >= (FRAME_W+1)'(NUM_FRAMES)) begin
            fq_tail = fq_tail - (FRAME_W+1)'(NUM_FRAMES);
        end
        fq_tail_idx = fq_tail[FRAME_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_page      = r_page;
        n_alloc     = r_alloc;
        n_mark      = r_mark;
        n_idx       = r_idx;
        n_frame     = r_frame;
        n_hit       = r_hit;
        n_push      = r_push;
        n_res       = r_res;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_fvalid    = r_fvalid;
        n_pins      = r_pins;
        n_dirty     = r_dirty;
        n_fq        = r_fq;
        n_fq_head   = r_fq_head;
        n_fq_cnt    = r_fq_cnt;
        n_lru       = r_lru;
        n_lru_cnt   = r_lru_cnt;
        ram_we      = 1'b0;
        ram_raddr   = r_idx;
        o_in_stall  = 1'b1;
        do_shift    = 1'b0;
        shift_from  = '0;

        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_op    = i_in_data.opcode;
                    n_page  = i_in_data.page_id;
                    n_alloc = i_in_data.allocated_page;
                    n_mark  = i_in_data.mark_dirty;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_push  = 1'b0;
                    n_res   = '{status: ST_NOT_RES, default: '0};
                    case (i_in_data.opcode)
                        OP_NEW: begin
                            n_state = S_TAKE;
                        end
                        OP_FETCH, OP_UNPIN, OP_FLUSH, OP_DELETE: begin
                            n_state = S_LOOK_RD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LOOK_RD: begin
                n_state = S_LOOK_CMP;
            end
            S_LOOK_CMP: begin
                if (r_fvalid[r_idx] && ram_rdata == r_page) begin
                    n_hit   = 1'b1;
                    n_frame = r_idx;
                    n_state = S_DECIDE;
                end else if (r_idx == FRAME_W'(NUM_FRAMES - 1)) begin
                    n_state = S_DECIDE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_LOOK_RD;
                end
            end
            S_DECIDE: begin
                n_idx   = '0;
                n_state = S_DONE;
                case (r_op)
                    OP_FETCH: begin
                        if (!r_hit) begin
                            n_state = S_TAKE;
                        end else if (r_pins[r_frame] >= PIN_W'(MAX_PINS)) begin
                            n_res.status = ST_PIN_ERR;
                        end else begin
                            n_pins[r_frame] = r_pins[r_frame] + 1'b1;
                            n_res.status    = ST_OK;
                            n_res.frame     = r_frame;
                            n_state         = S_LRU_SCAN;
                        end
                    end
                    OP_UNPIN: begin
                        if (r_hit) begin
                            if (r_pins[r_frame] == '0) begin
                                n_res.status = ST_PIN_ERR;
                            end else begin
                                n_pins[r_frame] = r_pins[r_frame] - 1'b1;
                                if (r_mark) begin
                                    n_dirty[r_frame] = 1'b1;
                                end
                                n_res.status = ST_OK;
                                n_res.frame  = r_frame;
                                if (r_pins[r_frame] == PIN_W'(1)) begin
                                    n_push  = 1'b1;
                                    n_state = S_LRU_SCAN;
                                end
                            end
                        end
                    end
                    OP_FLUSH: begin
                        if (r_hit) begin
                            n_res.disk_write_valid = 1'b1;
                            n_res.disk_write_page  = r_page;
                            n_dirty[r_frame]       = 1'b0;
                            n_res.status           = ST_OK;
                            n_res.frame            = r_frame;
                        end
                    end
                    OP_DELETE: begin
                        if (r_hit) begin
                            if (r_pins[r_frame] != '0) begin
                                n_res.status = ST_PIN_ERR;
                            end else begin
                                n_fvalid[r_frame] = 1'b0;
                                n_dirty[r_frame]  = 1'b0;
                                if (r_fq_cnt < CNT_W'(NUM_FRAMES)) begin
                                    n_fq[fq_tail_idx] = r_frame;
                                    n_fq_cnt          = r_fq_cnt + 1'b1;
                                end
                                n_res.status = ST_OK;
                                n_res.frame  = r_frame;
                                n_state      = S_LRU_SCAN;
                            end
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_TAKE: begin
                if (r_fq_cnt != '0) begin
                    n_frame  = r_fq[r_fq_head];
                    n_fq_cnt = r_fq_cnt - 1'b1;
                    if (r_fq_head == FRAME_W'(NUM_FRAMES - 1)) begin
                        n_fq_head = '0;
                    end else begin
                        n_fq_head = r_fq_head + 1'b1;
                    end
                    n_state = S_FILL;
                end else if (r_lru_cnt != '0) begin
                    n_frame    = r_lru[0];
                    ram_raddr  = r_lru[0];
                    do_shift   = 1'b1;
                    shift_from = '0;
                    n_lru_cnt  = r_lru_cnt - 1'b1;
                    n_state    = S_EVICT;
                end else begin
                    n_res.status = ST_NO_FRAME;
                    n_state      = S_DONE;
                end
            end
            S_EVICT: begin
                if (r_fvalid[r_frame] && r_dirty[r_frame]) begin
                    n_res.disk_write_valid = 1'b1;
                    n_res.disk_write_page  = ram_rdata;
                end
                n_state = S_FILL;
            end
            S_FILL: begin
                ram_we                = 1'b1;
                n_fvalid[r_frame]     = 1'b1;
                n_pins[r_frame]       = PIN_W'(1);
                n_dirty[r_frame]      = 1'b0;
                n_res.status          = ST_OK;
                n_res.frame           = r_frame;
                n_res.disk_read_valid = (r_op == OP_FETCH);
                n_state               = S_DONE;
            end
            S_LRU_SCAN: begin
                if (r_lru_cnt == '0) begin
                    n_state = r_push ? S_LRU_PUSH : S_DONE;
                end else if (r_lru[r_idx] == r_frame) begin
                    do_shift   = 1'b1;
                    shift_from = r_idx;
                    n_lru_cnt  = r_lru_cnt - 1'b1;
                    n_state    = r_push ? S_LRU_PUSH : S_DONE;
                end else if (CNT_W'(r_idx) + 1'b1 == r_lru_cnt) begin
                    n_state = r_push ? S_LRU_PUSH : S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LRU_PUSH: begin
                if (r_lru_cnt < CNT_W'(NUM_FRAMES)) begin
                    n_lru[r_lru_cnt[FRAME_W-1:0]] = r_frame;
                    n_lru_cnt                     = r_lru_cnt + 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_shift) begin
            for (int j = 0; j < NUM_FRAMES - 1; j++) begin
                if (FRAME_W'(j) >= shift_from) begin
                    n_lru[j] = r_lru[j+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fq_head   <= '0;
            r_fq_cnt    <= CNT_W'(NUM_FRAMES);
            r_lru_cnt   <= '0;
            for (int f = 0; f < NUM_FRAMES; f++) begin
                r_fvalid[f] <= 1'b0;
                r_pins[f]   <= '0;
                r_dirty[f]  <= 1'b0;
                r_fq[f]     <= FRAME_W'(f);
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_fq_head   <= n_fq_head;
            r_fq_cnt    <= n_fq_cnt;
            r_lru_cnt   <= n_lru_cnt;
            r_fvalid    <= n_fvalid;
            r_pins      <= n_pins;
            r_dirty     <= n_dirty;
            r_fq        <= n_fq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_page  <= n_page;
        r_alloc <= n_alloc;
        r_mark  <= n_mark;
        r_idx   <= n_idx;
        r_frame <= n_frame;
        r_hit   <= n_hit;
        r_push  <= n_push;
        r_res   <= n_res;
        r_out   <= n_out;
        r_lru   <= n_lru;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // free list and replacer never hold more than the pool
    a_fq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fq_cnt <= CNT_W'(NUM_FRAMES))
        else $error("free list count above pool size");

    a_lru_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lru_cnt <= CNT_W'(NUM_FRAMES))
        else $error("lru count above pool size");

    // an accepted request leaves idle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state != S_IDLE)
        else $error("sequencer stayed idle after input transfer");

    // a disk read only comes with a successful fetch
    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.disk_read_valid |-> r_out.status == ST_OK)
        else $error("disk read with failing status");

    // a result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("stalled result overwritten");

endmodule

FILE: hdl/pbp_ram.sv
// generic single write port ram with one registered read port
// no dependencies

module pbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
